@@ design/gb3_pkg.sv @@
// shared types and constants for the 3x3 gaussian blur block
package gb3_pkg;

	// field widths fixed by the stream format
	localparam int PIX_W   = 8;
	localparam int VAL_W   = 12;
	localparam int COORD_W = 10;
	localparam int CFG_W   = 11;
	localparam int CFG_A_W = 1;

	// configuration register indexes
	typedef enum logic [CFG_A_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// configuration reset values and smallest usable frame size
	localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd480;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd120;
	localparam logic [CFG_W-1:0] SIZE_MIN     = 11'd3;

	// result slots that one input beat can produce, in emission order
	localparam int RES_N        = 3;
	localparam int RES_DIAG     = 0;
	localparam int RES_ROW_END  = 1;
	localparam int RES_LAST_ROW = 2;

	typedef logic [RES_N-1:0] res_mask_t;

	// border pass-through: sample times sixteen in 8.4
	function automatic logic [VAL_W-1:0] pass_value(input logic [PIX_W-1:0] p);
		pass_value = {p, 4'b0000};
	endfunction

endpackage

@@ design/gb3_line_mem.sv @@
// line store: one write port and one registered read port
module gb3_line_mem
	import gb3_pkg::*;
#(
	parameter int DEPTH  = 1024,
	parameter int DATA_W = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ design/gaussian_blur_3x3_top.sv @@
// top level of the streaming 3x3 gaussian blur (1-2-1 kernel, 8.4 output)
//
//  channel  | direction | tdata (low bit up)                | tlast        | tuser
//  s_axis   | in        | pixel[7:0]                        | -            | -
//  m_axis   | out       | value[11:0] out_row[9:0] out_col  | last_of_run  | end_of_frame
//  cfg      | in        | index 0 frame_width, 1 frame_height, 11-bit data
//
// a pixel beat is registered into stage s1 together with the line store read
// of its column; the kernel sum is formed there and loaded into the output register.
// a pixel that yields at most one result leaves s1 as soon as the output register
// takes it; a pixel that yields two or three results holds s1 until the output
// register, which takes one result per cycle while not stalled, has taken them all.
// the first result of a pixel is registered in s1 and then in the output register.
// reset clears counters, valid flags and window; line stores are not cleared.
// output stalls back up through s1 to s_axis_tready.
module gaussian_blur_3x3_top
	import gb3_pkg::*;
#(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// pixel stream in
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,   // pixel[7:0]
	// result stream out
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [31:0]          m_axis_tdata,   // value[11:0], out_row[21:12], out_col[31:22]
	output logic                 m_axis_tlast,   // last_of_run
	output logic                 m_axis_tuser,   // end_of_frame
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_A_W-1:0]   cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int WSZ_A = $clog2(MAX_WIDTH + 1);
	localparam int HSZ_A = $clog2(MAX_HEIGHT + 1);
	localparam int WSZ_W = (WSZ_A > CFG_W) ? WSZ_A : CFG_W;
	localparam int HSZ_W = (HSZ_A > CFG_W) ? HSZ_A : CFG_W;
	localparam int MEM_W = 2 * PIX_W;

	// configuration registers
	logic [CFG_W-1:0] frame_width_q, frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// frame size in use, clamped to the supported range
	logic [WSZ_W-1:0] width_use, width_cfg_ext;
	logic [HSZ_W-1:0] height_use, height_cfg_ext;

	always_comb begin
		width_cfg_ext  = WSZ_W'(frame_width_q);
		height_cfg_ext = HSZ_W'(frame_height_q);
		if (frame_width_q < SIZE_MIN)
			width_use = WSZ_W'(SIZE_MIN);
		else if (width_cfg_ext > WSZ_W'(MAX_WIDTH))
			width_use = WSZ_W'(MAX_WIDTH);
		else
			width_use = width_cfg_ext;
		if (frame_height_q < SIZE_MIN)
			height_use = HSZ_W'(SIZE_MIN);
		else if (height_cfg_ext > HSZ_W'(MAX_HEIGHT))
			height_use = HSZ_W'(MAX_HEIGHT);
		else
			height_use = height_cfg_ext;
	end

	// handshake control
	logic s_fire, s1_retire, out_load;
	logic valid_s1;

	assign s_axis_tready = !valid_s1 || s1_retire;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	// raster position of the incoming pixel
	logic [CW-1:0] col_cnt_q, col_cur;
	logic [RW-1:0] row_cnt_q, row_cur;
	logic          pos_restart;
	logic [WSZ_W-1:0] col_next;
	logic [HSZ_W-1:0] row_next;
	logic          col_is_last, row_is_last;

	always_comb begin
		pos_restart = (WSZ_W'(col_cnt_q) >= width_use) || (HSZ_W'(row_cnt_q) >= height_use);
		col_cur     = pos_restart ? '0 : col_cnt_q;
		row_cur     = pos_restart ? '0 : row_cnt_q;
		col_is_last = WSZ_W'(col_cur) == (width_use - WSZ_W'(1));
		row_is_last = HSZ_W'(row_cur) == (height_use - HSZ_W'(1));
		col_next    = WSZ_W'(col_cur) + WSZ_W'(1);
		row_next    = HSZ_W'(row_cur) + HSZ_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			row_cnt_q <= '0;
		end else if (s_fire) begin
			if (col_next >= width_use) begin
				col_cnt_q <= '0;
				row_cnt_q <= (row_next >= height_use) ? '0 : RW'(row_next);
			end else begin
				col_cnt_q <= CW'(col_next);
				row_cnt_q <= row_cur;
			end
		end
	end

	// line stores: high byte is row r-2, low byte is row r-1
	logic [MEM_W-1:0] line_rd;
	logic [MEM_W-1:0] line_rd_wdata;
	logic [CW-1:0]    col_s1;

	gb3_line_mem #(
		.DEPTH  (MAX_WIDTH),
		.DATA_W (MEM_W)
	) u_line_mem (
		.clk     (clk),
		.wr_en   (s1_retire),
		.wr_addr (col_s1),
		.wr_data (line_rd_wdata),
		.rd_en   (s_fire),
		.rd_addr (col_cur),
		.rd_data (line_rd)
	);

	// stage s1: pixel, position and result plan
	logic [PIX_W-1:0] pix_s1;
	logic [RW-1:0]    row_s1;
	res_mask_t        pend_s1;
	res_mask_t        res_sel, pend_left;
	logic             inner_s1, eof_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			pix_s1   <= s_axis_tdata;
			row_s1   <= row_cur;
			col_s1   <= col_cur;
			inner_s1 <= (row_cur >= RW'(2)) && (col_cur >= CW'(2));
			eof_s1   <= row_is_last && col_is_last;
			pend_s1[RES_DIAG]     <= (row_cur != '0) && (col_cur != '0);
			pend_s1[RES_ROW_END]  <= (row_cur != '0) && col_is_last;
			pend_s1[RES_LAST_ROW] <= row_is_last;
		end else if (out_load) begin
			pend_s1 <= pend_s1 & ~res_sel;
		end
	end

	// 3x2 window of the two previous columns: older, newer, current rows
	logic [PIX_W-1:0] win_q [6];
	logic [PIX_W-1:0] old_px, new_px;

	assign old_px        = line_rd[MEM_W-1:PIX_W];
	assign new_px        = line_rd[PIX_W-1:0];
	assign line_rd_wdata = {new_px, pix_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else if (s1_retire) begin
			win_q[0] <= win_q[1];
			win_q[1] <= old_px;
			win_q[2] <= win_q[3];
			win_q[3] <= new_px;
			win_q[4] <= win_q[5];
			win_q[5] <= pix_s1;
		end
	end

	// kernel sum 1-2-1 / 2-4-2 / 1-2-1
	logic [VAL_W-1:0] kern_sum;

	always_comb begin
		kern_sum = VAL_W'(win_q[0]) + (VAL_W'(win_q[1]) << 1) + VAL_W'(old_px)
			+ (VAL_W'(win_q[2]) << 1) + (VAL_W'(win_q[3]) << 2) + (VAL_W'(new_px) << 1)
			+ VAL_W'(win_q[4]) + (VAL_W'(win_q[5]) << 1) + VAL_W'(pix_s1);
	end

	// pick the next pending result of the pixel in s1
	logic [VAL_W-1:0] res_value;
	logic [RW-1:0]    res_row;
	logic [CW-1:0]    res_col;
	logic             out_free;

	always_comb begin
		res_sel   = '0;
		res_value = pass_value(pix_s1);
		res_row   = row_s1;
		res_col   = col_s1;
		if (pend_s1[RES_DIAG]) begin
			res_sel[RES_DIAG] = 1'b1;
			res_value = inner_s1 ? kern_sum : pass_value(win_q[3]);
			res_row   = row_s1 - RW'(1);
			res_col   = col_s1 - CW'(1);
		end else if (pend_s1[RES_ROW_END]) begin
			res_sel[RES_ROW_END] = 1'b1;
			res_value = pass_value(new_px);
			res_row   = row_s1 - RW'(1);
		end else if (pend_s1[RES_LAST_ROW]) begin
			res_sel[RES_LAST_ROW] = 1'b1;
		end
		pend_left = pend_s1 & ~res_sel;
	end

	assign out_free  = !m_axis_tvalid || m_axis_tready;
	assign out_load  = valid_s1 && (pend_s1 != '0) && out_free;
	assign s1_retire = valid_s1 && ((pend_s1 == '0) || (out_load && (pend_left == '0)));

	// output register
	logic             m_valid_q;
	logic [VAL_W-1:0] m_value_q;
	logic [COORD_W-1:0] m_row_q, m_col_q;
	logic             m_last_q, m_eof_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= out_load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_value_q <= res_value;
			m_row_q   <= COORD_W'(res_row);
			m_col_q   <= COORD_W'(res_col);
			m_last_q  <= (pend_left == '0);
			m_eof_q   <= (pend_left == '0) && eof_s1;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {m_col_q, m_row_q, m_value_q};
	assign m_axis_tlast  = m_last_q;
	assign m_axis_tuser  = m_eof_q;

endmodule

@@ tb/sv/testbench.sv @@
// testbench for the 3x3 gaussian blur: scoreboard with its own blur predictor, framed stimulus
typedef struct packed {
	logic [11:0] value;
	logic [9:0]  out_row;
	logic [9:0]  out_col;
	logic        last_of_run;
	logic        end_of_frame;
} blur_result_t;

class blur_scoreboard;
	localparam int unsigned MAX_W = 1024;
	localparam int unsigned MAX_H = 1024;

	// own copy of the line stores, window, counters and size registers
	logic [7:0]   older_row [0:MAX_W-1];
	logic [7:0]   newer_row [0:MAX_W-1];
	logic [7:0]   win [0:5];
	int unsigned  row_idx;
	int unsigned  col_idx;
	logic [10:0]  width_reg;
	logic [10:0]  height_reg;

	blur_result_t blurred_q [$];
	int unsigned  err_count;
	int unsigned  pixel_count;
	int unsigned  result_count;

	function new();
		foreach (older_row[i]) older_row[i] = 8'd0;
		foreach (newer_row[i]) newer_row[i] = 8'd0;
		foreach (win[i]) win[i] = 8'd0;
		row_idx = 0;
		col_idx = 0;
		width_reg = gb3_pkg::WIDTH_RESET;
		height_reg = gb3_pkg::HEIGHT_RESET;
		err_count = 0;
		pixel_count = 0;
		result_count = 0;
	endfunction

	// out-of-range sizes are clamped to 3..max
	function int unsigned size_in_use(logic [10:0] v, int unsigned maxv);
		if (v < 11'd3) return 3;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function int unsigned width_in_use();
		return size_in_use(width_reg, MAX_W);
	endfunction

	function int unsigned height_in_use();
		return size_in_use(height_reg, MAX_H);
	endfunction

	function int unsigned pending();
		return blurred_q.size();
	endfunction

	function void set_register(gb3_pkg::cfg_reg_t idx, logic [10:0] data);
		if (idx == gb3_pkg::REG_FRAME_WIDTH)
			width_reg = data;
		else if (idx == gb3_pkg::REG_FRAME_HEIGHT)
			height_reg = data;
	endfunction

	function void push_result(int unsigned val, int unsigned r, int unsigned c);
		blur_result_t res;
		res.value = val[11:0];
		res.out_row = r[9:0];
		res.out_col = c[9:0];
		res.last_of_run = 1'b0;
		res.end_of_frame = 1'b0;
		blurred_q.insert(blurred_q.size(), res);
	endfunction

	// predict the results caused by one accepted pixel beat
	function void note_pixel(logic [7:0] p);
		int unsigned w, h, r, c, o, n, val;
		int k;
		w = width_in_use();
		h = height_in_use();
		pixel_count++;
		// counters past a shrunk size open a new frame
		if (col_idx >= w || row_idx >= h) begin
			col_idx = 0;
			row_idx = 0;
		end
		r = row_idx;
		c = col_idx;
		o = older_row[c];
		n = newer_row[c];
		k = 0;
		// pixel up and to the left: kernel if interior, else pass-through
		if (r >= 1 && c >= 1) begin
			if (r >= 2 && c >= 2)
				val = int'(win[0]) + 2 * int'(win[1]) + o
					+ 2 * (int'(win[2]) + 2 * int'(win[3]) + n)
					+ int'(win[4]) + 2 * int'(win[5]) + int'(p);
			else
				val = int'(win[3]) * 16;
			push_result(val, r - 1, c - 1);
			k++;
		end
		// right border of the row above
		if (r >= 1 && c == w - 1) begin
			push_result(n * 16, r - 1, c);
			k++;
		end
		// bottom border passes straight through
		if (r == h - 1) begin
			push_result(int'(p) * 16, r, c);
			k++;
		end
		if (k > 0) begin
			blurred_q[blurred_q.size() - 1].last_of_run = 1'b1;
			if (r == h - 1 && c == w - 1)
				blurred_q[blurred_q.size() - 1].end_of_frame = 1'b1;
		end
		// shift window and update line stores
		win[0] = win[1]; win[1] = o[7:0];
		win[2] = win[3]; win[3] = n[7:0];
		win[4] = win[5]; win[5] = p;
		older_row[c] = n[7:0];
		newer_row[c] = p;
		col_idx = c + 1;
		if (col_idx >= w) begin
			col_idx = 0;
			row_idx = r + 1;
			if (row_idx >= h)
				row_idx = 0;
		end
	endfunction

	// compare one result beat with the oldest prediction
	function void check_result(logic [31:0] data, logic last, logic eof);
		blur_result_t exp_res;
		if (blurred_q.size() == 0) begin
			$error("result beat with nothing expected: tdata %h", data);
			err_count++;
			return;
		end
		exp_res = blurred_q.pop_front();
		result_count++;
		if (data[11:0] !== exp_res.value) begin
			$error("value expected %0d got %0d", exp_res.value, data[11:0]);
			err_count++;
		end
		if (data[21:12] !== exp_res.out_row) begin
			$error("out_row expected %0d got %0d", exp_res.out_row, data[21:12]);
			err_count++;
		end
		if (data[31:22] !== exp_res.out_col) begin
			$error("out_col expected %0d got %0d", exp_res.out_col, data[31:22]);
			err_count++;
		end
		if (last !== exp_res.last_of_run) begin
			$error("last_of_run expected %0d got %0d", exp_res.last_of_run, last);
			err_count++;
		end
		if (eof !== exp_res.end_of_frame) begin
			$error("end_of_frame expected %0d got %0d", exp_res.end_of_frame, eof);
			err_count++;
		end
	endfunction
endclass

module testbench
	import gb3_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES = 400;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata;    // pixel[7:0]
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [31:0]        m_axis_tdata;    // value[11:0], out_row[21:12], out_col[31:22]
	logic               m_axis_tlast;    // last_of_run
	logic               m_axis_tuser;    // end_of_frame
	logic               cfg_we;
	logic [CFG_A_W-1:0] cfg_addr;
	logic [CFG_W-1:0]   cfg_wdata;

	blur_scoreboard sb = new();
	bit          idle_on = 1'b1;
	bit          hold_out = 1'b0;
	int unsigned size_count = 0;
	int unsigned cfg_count = 0;

	gaussian_blur_3x3_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// result beat monitor
	always @(posedge clk) begin
		if (arst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
			sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_out) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_out = 1'b0;
			end else if (idle_on && $urandom_range(0, 6) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// run limit
	initial begin
		#40000000;
		$display("FAIL gaussian_blur_3x3_top");
		$finish;
	end

	function automatic logic [7:0] pick_pixel();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// one pixel beat, with an optional gap in front
	task automatic send_pixel(input logic [7:0] pix);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pix;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		sb.note_pixel(pix);
	endtask

	task automatic send_pixels(input int unsigned count);
		repeat (count) send_pixel(pick_pixel());
	endtask

	task automatic full_frame();
		send_pixels(sb.width_in_use() * sb.height_in_use());
	endtask

	// stop offering and let the block drain before touching registers
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_cfg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_register(idx, data);
		cfg_count++;
		@(posedge clk);
	endtask

	// random frame sizes, some frames cut short by a width shrink
	task automatic random_frames(input int unsigned target);
		int unsigned raw_w, raw_h, w, h, cc, rr;
		while (sb.pixel_count < target) begin
			wait_idle();
			raw_w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
			raw_h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
			write_cfg(REG_FRAME_WIDTH, raw_w[CFG_W-1:0]);
			write_cfg(REG_FRAME_HEIGHT, raw_h[CFG_W-1:0]);
			size_count++;
			w = sb.width_in_use();
			h = sb.height_in_use();
			if (w >= 4 && $urandom_range(0, 4) == 0) begin
				cc = $urandom_range(3, w - 1);
				rr = $urandom_range(0, h - 1);
				send_pixels(rr * w + cc);
				wait_idle();
				// width at or below the column restarts the frame
				write_cfg(REG_FRAME_WIDTH, CFG_W'($urandom_range(3, cc)));
				size_count++;
			end
			full_frame();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= 8'd0;
		cfg_we <= 1'b0;
		cfg_addr <= REG_FRAME_WIDTH;
		cfg_wdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: a few beats at reset size, then width zero restarts the frame
		send_pixel(8'd0);
		send_pixel(8'd255);
		send_pixel(8'h55);
		wait_idle();
		write_cfg(REG_FRAME_WIDTH, 11'd0);
		write_cfg(REG_FRAME_HEIGHT, 11'd4);
		size_count++;
		send_pixel(8'hAA);
		send_pixels(9);
		// row count past a shrunk height restarts the frame
		wait_idle();
		write_cfg(REG_FRAME_HEIGHT, 11'd2);
		size_count++;
		for (int i = 0; i < 9; i++)
			send_pixel((i % 2 == 0) ? 8'd255 : 8'd0);

		// random frames with gaps and stalls on both sides
		random_frames(sb.pixel_count + 130);

		// long output hold-off while the input keeps offering
		wait_idle();
		write_cfg(REG_FRAME_WIDTH, 11'd10);
		write_cfg(REG_FRAME_HEIGHT, 11'd6);
		size_count++;
		hold_out = 1'b1;
		full_frame();

		// all-ones register values clamp to the maximum; a short stretch
		// of each, then a shrink restarts the frame
		wait_idle();
		write_cfg(REG_FRAME_WIDTH, 11'h7FF);
		write_cfg(REG_FRAME_HEIGHT, 11'd3);
		size_count++;
		send_pixels(24);
		wait_idle();
		write_cfg(REG_FRAME_WIDTH, 11'd16);
		size_count++;
		full_frame();
		wait_idle();
		write_cfg(REG_FRAME_WIDTH, 11'd3);
		write_cfg(REG_FRAME_HEIGHT, 11'h7FF);
		size_count++;
		send_pixels(42);
		wait_idle();
		write_cfg(REG_FRAME_HEIGHT, 11'd6);
		size_count++;
		full_frame();

		// closing stretch at full rate
		wait_idle();
		idle_on = 1'b0;
		random_frames(sb.pixel_count + 60);

		wait_idle();
		repeat (20) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d expected results never arrived", sb.pending());
			sb.err_count++;
		end
		$display("sent %0d pixel beats over %0d frame sizes with %0d register writes",
			sb.pixel_count, size_count, cfg_count);
		$display("checked %0d result beats, incl. clamped sizes and a %0d-cycle hold",
			sb.result_count, HOLD_CYCLES);
		if (sb.err_count == 0)
			$display("PASS gaussian_blur_3x3_top");
		else
			$display("FAIL gaussian_blur_3x3_top");
		$finish;
	end
endmodule

@@ files.f @@
design/gb3_pkg.sv
design/gb3_line_mem.sv
design/gaussian_blur_3x3_top.sv
tb/sv/testbench.sv
